/* design/awcd_pkg.sv */
// ============================================================================
// awcd_pkg : shared constants and helpers for the adaptive window clap detector
// Field widths, register map, reset values, controller states and saturation.
// ============================================================================
package awcd_pkg;

    // Sample ring; the depth must be a power of two (index wraps by truncation)
    localparam int RING_DEPTH = 256;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int WIN_W      = 8;
    localparam int MARGIN_W   = 16;
    localparam int LEVEL_W    = 15;
    localparam int MAG_W      = SAMPLE_W;              // |most negative| fits unsigned
    localparam int SUM_W      = MAG_W + WIN_W - 1;     // 255 * 2^15 < 2^23
    localparam int DCNT_W     = $clog2(SUM_W);
    localparam int WIDE_W     = SAMPLE_W + 2;          // level + offset before saturation

    // APB register map (word index taken from paddr[3:2])
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_UPPER  = 2'd1;
    localparam logic [1:0] REG_LOWER  = 2'd2;
    localparam logic [1:0] REG_MARGIN = 2'd3;

    // Reset values
    localparam logic [WIN_W-1:0]           WINDOW_RST = 8'd16;
    localparam logic signed [SAMPLE_W-1:0] UPPER_RST  = 16'sd2000;
    localparam logic signed [SAMPLE_W-1:0] LOWER_RST  = 16'sd500;
    localparam logic [MARGIN_W-1:0]        MARGIN_RST = 16'd64;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_DIV   = 6'b000100,
        S_ADAPT = 6'b001000,
        S_THR   = 6'b010000,
        S_DONE  = 6'b100000
    } awcd_state_t;

    // Clamp a widened sum to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi)
        begin
            sat_sample = hi[SAMPLE_W-1:0];
        end
        else if (v < lo)
        begin
            sat_sample = lo[SAMPLE_W-1:0];
        end
        else
        begin
            sat_sample = v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

/* design/awcd_ram.sv */
// ============================================================================
// awcd_ram : generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module awcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/adaptive_window_clap_detector_top.sv */
// ============================================================================
// adaptive_window_clap_detector_top : hysteresis clap detector, adaptive levels
// Sequenced store / average / divide / threshold update around one ring RAM.
// ============================================================================
// Usage
//   Input channel: in_valid / in_stall with one signed sample per request.
//   Output channel: out_valid / out_stall with one result per accepted sample
//   (clap flag, release mode, noise level and both thresholds after the sample).
//   APB port: window_count, upper_offset, lower_offset, update_margin at byte
//   addresses 0, 4, 8 and 12; write only while the block is idle.
// Sequencing
//   A sample that claps or re-arms goes straight to the output load.
//   A stored sample runs one RAM read per window entry through a single
//   accumulator, a 23-step restoring divider, the level compare and, when
//   the levels move, the threshold update, then the output load. With
//   window_count of zero the stored sample goes straight to the output load.
//   in_stall is high from acceptance until the result is in the output
//   register; the next sample is taken in the cycle after that at the earliest.
// Reset
//   Ring reads as all zero (unwritten entries are masked by a write pointer and
//   a wrap flag, no clearing pass), thresholds start at the reset offsets.
//   If out_stall holds, the finished result waits in the sequencer and the
//   output register keeps the previous one until taken.
// ============================================================================
module adaptive_window_clap_detector_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [awcd_pkg::SAMPLE_W-1:0]   sample,
    // Output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   clap_seen,
    output logic                                   awaiting_release,
    output logic [awcd_pkg::LEVEL_W-1:0]           noise_level,
    output logic signed [awcd_pkg::SAMPLE_W-1:0]   upper_threshold,
    output logic signed [awcd_pkg::SAMPLE_W-1:0]   lower_threshold,
    // Configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [awcd_pkg::PADDR_W-1:0]           paddr,
    input  logic [awcd_pkg::PDATA_W-1:0]           pwdata,
    output logic [awcd_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    import awcd_pkg::*;

    // Configuration registers
    logic [WIN_W-1:0]           window_reg;
    logic signed [SAMPLE_W-1:0] upper_off_reg;
    logic signed [SAMPLE_W-1:0] lower_off_reg;
    logic [MARGIN_W-1:0]        margin_reg;

    // Controller and datapath state
    awcd_state_t                state_reg,   state_next;
    logic [ADDR_W-1:0]          widx_reg,    widx_next;
    logic                       wrapped_reg, wrapped_next;
    logic [LEVEL_W-1:0]         kept_reg,    kept_next;
    logic signed [SAMPLE_W-1:0] high_reg,    high_next;
    logic signed [SAMPLE_W-1:0] low_reg,     low_next;
    logic                       release_reg, release_next;
    logic                       clap_reg,    clap_next;
    logic [WIN_W-1:0]           cnt_reg,     cnt_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic                       rd_ok_reg,   rd_ok_next;
    logic [SUM_W-1:0]           acc_reg,     acc_next;
    logic [WIN_W-1:0]           rem_reg,     rem_next;
    logic [DCNT_W-1:0]          dcnt_reg,    dcnt_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic                       out_clap_reg;
    logic                       out_release_reg;
    logic [LEVEL_W-1:0]         out_level_reg;
    logic signed [SAMPLE_W-1:0] out_upper_reg;
    logic signed [SAMPLE_W-1:0] out_lower_reg;
    logic                       out_load;

    // Misc combinational signals
    logic                       in_accept;
    logic                       hit_upper;
    logic                       hit_lower;
    logic                       ram_we;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SAMPLE_W-1:0]        rd_data;
    logic [MAG_W-1:0]           rd_mag;
    logic                       issue;
    logic [WIN_W:0]             trial;
    logic                       trial_ge;
    logic [MAG_W:0]             avg_ext;
    logic [MAG_W:0]             kept_ext;
    logic [MAG_W:0]             diff_mag;
    logic                       cfg_wr;

    // ------------------------------------------------------------------
    // APB configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RST;
            upper_off_reg <= UPPER_RST;
            lower_off_reg <= LOWER_RST;
            margin_reg    <= MARGIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WINDOW: window_reg    <= pwdata[WIN_W-1:0];
                REG_UPPER:  upper_off_reg <= pwdata[SAMPLE_W-1:0];
                REG_LOWER:  lower_off_reg <= pwdata[SAMPLE_W-1:0];
                REG_MARGIN: margin_reg    <= pwdata[MARGIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WINDOW: prdata = PDATA_W'(window_reg);
            REG_UPPER:  prdata = PDATA_W'(unsigned'(upper_off_reg));
            REG_LOWER:  prdata = PDATA_W'(unsigned'(lower_off_reg));
            REG_MARGIN: prdata = PDATA_W'(margin_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sample ring
    // ------------------------------------------------------------------
    awcd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (widx_reg),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Shared datapath terms
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign hit_upper = !release_reg && (sample > high_reg);
    assign hit_lower = release_reg && (sample < low_reg);
    assign ram_we    = in_accept && !hit_upper && !hit_lower;

    // Walk backwards from the newest entry
    assign rd_addr = widx_reg - ADDR_W'(1) - ADDR_W'(cnt_reg);
    assign issue   = (cnt_reg != window_reg);
    assign rd_mag  = rd_data[SAMPLE_W-1] ? (~rd_data + MAG_W'(1)) : rd_data;

    // Restoring divide step
    assign trial    = {rem_reg, acc_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, window_reg});

    // Level change magnitude
    assign avg_ext  = {1'b0, acc_reg[MAG_W-1:0]};
    assign kept_ext = (MAG_W+1)'(kept_reg);
    assign diff_mag = (avg_ext >= kept_ext) ? (avg_ext - kept_ext) : (kept_ext - avg_ext);

    assign out_load = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        wrapped_next   = wrapped_reg;
        kept_next      = kept_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        release_next   = release_reg;
        clap_next      = clap_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = rd_pend_reg;
        rd_ok_next     = rd_ok_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    clap_next    = hit_upper;
                    cnt_next     = '0;
                    acc_next     = '0;
                    rd_pend_next = 1'b0;
                    if (hit_upper)
                    begin
                        release_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (hit_lower)
                    begin
                        release_next = 1'b0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        widx_next    = widx_reg + ADDR_W'(1);
                        wrapped_next = wrapped_reg || (widx_reg == {ADDR_W{1'b1}});
                        state_next   = (window_reg != '0) ? S_SUM : S_DONE;
                    end
                end
            end

            S_SUM:
            begin
                // One RAM read issued per cycle, accumulated in the cycle after
                rd_pend_next = issue;
                if (issue)
                begin
                    cnt_next   = cnt_reg + WIN_W'(1);
                    rd_ok_next = wrapped_reg || (rd_addr < widx_reg);
                end
                if (rd_pend_reg && rd_ok_reg)
                begin
                    acc_next = acc_reg + SUM_W'(rd_mag);
                end
                if (!issue && !rd_pend_reg)
                begin
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // One quotient bit per cycle, quotient shifts into acc
                rem_next  = trial_ge ? WIN_W'(trial - {1'b0, window_reg}) : WIN_W'(trial);
                acc_next  = {acc_reg[SUM_W-2:0], trial_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(SUM_W - 1))
                begin
                    state_next = S_ADAPT;
                end
            end

            S_ADAPT:
            begin
                if (diff_mag > (MAG_W+1)'(margin_reg))
                begin
                    kept_next  = acc_reg[MAG_W-1:1];
                    state_next = S_THR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_THR:
            begin
                high_next  = sat_sample(signed'(WIDE_W'(kept_reg))
                                        + WIDE_W'(upper_off_reg));
                low_next   = sat_sample(signed'(WIDE_W'(kept_reg))
                                        + WIDE_W'(lower_off_reg));
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and level registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            widx_reg      <= '0;
            wrapped_reg   <= 1'b0;
            kept_reg      <= '0;
            high_reg      <= UPPER_RST;
            low_reg       <= LOWER_RST;
            release_reg   <= 1'b0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            wrapped_reg   <= wrapped_next;
            kept_reg      <= kept_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            release_reg   <= release_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        clap_reg  <= clap_next;
        rd_ok_reg <= rd_ok_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        if ((state_reg == S_DONE) && out_load)
        begin
            out_clap_reg    <= clap_reg;
            out_release_reg <= release_reg;
            out_level_reg   <= kept_reg;
            out_upper_reg   <= high_reg;
            out_lower_reg   <= low_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign clap_seen        = out_clap_reg;
    assign awaiting_release = out_release_reg;
    assign noise_level      = out_level_reg;
    assign upper_threshold  = out_upper_reg;
    assign lower_threshold  = out_lower_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < window_reg))
        else $error("divider remainder out of range");

    // Read walk never passes the window
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (cnt_reg <= window_reg))
        else $error("ring read count beyond window");

    // A clapping sample goes straight to the result
    a_clap_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && hit_upper) |=> ((state_reg == S_DONE) && release_reg && clap_reg))
        else $error("clap not routed to result");

    // A reported clap always leaves the detector in release mode
    a_clap_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clap_seen) |-> awaiting_release)
        else $error("clap reported while armed");

    // Halved average of 16-bit magnitudes never exceeds 2^14
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_THR) |-> (kept_reg <= LEVEL_W'(16384)))
        else $error("noise level out of range");

endmodule

/* dv/clap_result_checker.sv */
// ============================================================================
// clap_result_checker : result predictor and comparator for the clap detector
// Watches the sample, result and APB channels, keeps its own copy of the
// detector state and register values, predicts one result per accepted
// sample request and compares each delivered result field by field.
// ============================================================================
`timescale 1ns / 1ps

module clap_result_checker
    import awcd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Sample channel
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [SAMPLE_W-1:0]   sample,
    // Result channel
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         clap_seen,
    input  logic                         awaiting_release,
    input  logic [LEVEL_W-1:0]           noise_level,
    input  logic signed [SAMPLE_W-1:0]   upper_threshold,
    input  logic signed [SAMPLE_W-1:0]   lower_threshold,
    // APB
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    // Status towards the testbench top
    output int                           fail_count,
    output int                           pending_count
);

    typedef struct packed {
        logic                       clap;
        logic                       release_mode;
        logic [LEVEL_W-1:0]         level;
        logic signed [SAMPLE_W-1:0] upper;
        logic signed [SAMPLE_W-1:0] lower;
    } clap_result_t;

    // Register copies
    logic [WIN_W-1:0]           window_count;
    logic signed [SAMPLE_W-1:0] upper_offset;
    logic signed [SAMPLE_W-1:0] lower_offset;
    logic [MARGIN_W-1:0]        update_margin;

    // Detector state copies
    logic signed [SAMPLE_W-1:0] history [RING_DEPTH];
    logic [ADDR_W-1:0]          history_ptr;
    logic [LEVEL_W-1:0]         kept_level;
    logic signed [SAMPLE_W-1:0] trigger_level;
    logic signed [SAMPLE_W-1:0] rearm_level;
    logic                       in_release;

    clap_result_t expected_results [$];
    clap_result_t oldest;
    int           errors = 0;

    // Clamp to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] clamp_to_sample(input int v);
        int hi;
        int lo;
        hi = (1 << (SAMPLE_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            v = hi;
        end
        else if (v < lo)
        begin
            v = lo;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic void reset_detector_copy();
        window_count  = WINDOW_RST;
        upper_offset  = UPPER_RST;
        lower_offset  = LOWER_RST;
        update_margin = MARGIN_RST;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            history[i] = '0;
        end
        history_ptr   = '0;
        kept_level    = '0;
        trigger_level = UPPER_RST;
        rearm_level   = LOWER_RST;
        in_release    = 1'b0;
    endfunction

    // Store a quiet sample, then re-average the window and move the levels if the change exceeds the margin
    function automatic void store_and_track(input logic signed [SAMPLE_W-1:0] s);
        int                n;
        int                k;
        int                mag;
        int                avg;
        int                diff;
        int                lvl;
        int                up;
        int                lo;
        longint            sum;
        logic [ADDR_W-1:0] pos;
        history[history_ptr] = s;
        history_ptr = history_ptr + 1'b1;
        n = window_count;
        if (n == 0)
        begin
            return;
        end
        pos = history_ptr;
        sum = 0;
        for (k = 0; k < n; k++)
        begin
            pos = pos - 1'b1;
            mag = history[pos];
            if (mag < 0)
            begin
                mag = -mag;
            end
            sum += mag;
        end
        avg  = int'(sum / n);
        lvl  = kept_level;
        diff = avg - lvl;
        if (diff < 0)
        begin
            diff = -diff;
        end
        if (diff > int'(update_margin))
        begin
            kept_level    = LEVEL_W'(avg / 2);
            lvl           = kept_level;
            up            = upper_offset;
            lo            = lower_offset;
            trigger_level = clamp_to_sample(lvl + up);
            rearm_level   = clamp_to_sample(lvl + lo);
        end
    endfunction

    // Hysteresis decision for one sample request
    function automatic clap_result_t predict_clap_step(input logic signed [SAMPLE_W-1:0] s);
        clap_result_t r;
        logic         clap;
        clap = 1'b0;
        if (!in_release)
        begin
            if (s > trigger_level)
            begin
                clap       = 1'b1;
                in_release = 1'b1;
            end
            else
            begin
                store_and_track(s);
            end
        end
        else
        begin
            if (s < rearm_level)
            begin
                in_release = 1'b0;
            end
            else
            begin
                store_and_track(s);
            end
        end
        r.clap         = clap;
        r.release_mode = in_release;
        r.level        = kept_level;
        r.upper        = trigger_level;
        r.lower        = rearm_level;
        return r;
    endfunction

    function automatic void check_field(
        input string               name,
        input logic [SAMPLE_W-1:0] expv,
        input logic [SAMPLE_W-1:0] actv
    );
        if (actv !== expv)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_detector_copy();
            expected_results.delete();
            pending_count <= 0;
            fail_count    <= errors;
        end
        else
        begin
            // Delivered result against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request outstanding: clap %0b release %0b level 0x%0h",
                             $time, clap_seen, awaiting_release, noise_level);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("clap_seen", SAMPLE_W'(oldest.clap), SAMPLE_W'(clap_seen));
                    check_field("awaiting_release", SAMPLE_W'(oldest.release_mode),
                                SAMPLE_W'(awaiting_release));
                    check_field("noise_level", SAMPLE_W'(oldest.level), SAMPLE_W'(noise_level));
                    check_field("upper_threshold", oldest.upper, upper_threshold);
                    check_field("lower_threshold", oldest.lower, lower_threshold);
                end
            end

            // Register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WINDOW: window_count  = pwdata[WIN_W-1:0];
                    REG_UPPER:  upper_offset  = pwdata[SAMPLE_W-1:0];
                    REG_LOWER:  lower_offset  = pwdata[SAMPLE_W-1:0];
                    REG_MARGIN: update_margin = pwdata[MARGIN_W-1:0];
                    default: ;
                endcase
            end

            // New sample request
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_clap_step(sample));
            end

            fail_count    <= errors;
            pending_count <= expected_results.size();
        end
    end

endmodule

/* dv/testbench.sv */
// ============================================================================
// testbench : stimulus and verdict for adaptive_window_clap_detector_top
// Drives directed and random sample requests with random idling on both
// channels, reprograms the registers between phases over APB, and reports
// the outcome from the checker's failure count.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import awcd_pkg::*;

    localparam int QUIET_LIMIT = 5000;     // cycles with no handshake at all
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 96;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       clap_seen;
    logic                       awaiting_release;
    logic [LEVEL_W-1:0]         noise_level;
    logic signed [SAMPLE_W-1:0] upper_threshold;
    logic signed [SAMPLE_W-1:0] lower_threshold;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    int fail_count;
    int pending_count;
    bit idling_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    adaptive_window_clap_detector_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .clap_seen        (clap_seen),
        .awaiting_release (awaiting_release),
        .noise_level      (noise_level),
        .upper_threshold  (upper_threshold),
        .lower_threshold  (lower_threshold),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    clap_result_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .clap_seen        (clap_seen),
        .awaiting_release (awaiting_release),
        .noise_level      (noise_level),
        .upper_threshold  (upper_threshold),
        .lower_threshold  (lower_threshold),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    // Result-side back-pressure in short random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: no handshake on any port for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("adaptive_window_clap_detector_top verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // One sample request, with an optional idle gap ahead of it
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_register(input logic [1:0] index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every request has its result back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int                         ph;
        int                         i;
        int                         roll;
        int                         amp;
        int                         upper_val;
        int                         lower_val;
        int                         margin_val;
        int                         window_val;
        logic signed [SAMPLE_W-1:0] s;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: quiet samples, a clap, a re-arm, most negative sample
        push_sample(16'sd0);
        push_sample(16'sd300);
        push_sample(-16'sd300);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sd1);
        push_sample(-16'sd1);

        // Zero window: quiet samples are stored but levels stay put
        drain_results();
        write_register(REG_WINDOW, 32'd0);
        push_sample(16'sd5000);
        push_sample(-16'sd5000);
        push_sample(16'sd100);

        // Full window, widest offsets, zero margin: upper level saturates
        drain_results();
        write_register(REG_WINDOW, 32'd255);
        write_register(REG_UPPER, 32'h0000_7fff);
        write_register(REG_LOWER, 32'h0000_8000);
        write_register(REG_MARGIN, 32'd0);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sd0);
        push_sample(16'sd12345);

        // Single-entry window, inverted offsets, margin of 2^15 that no level change exceeds
        drain_results();
        write_register(REG_WINDOW, 32'd1);
        write_register(REG_UPPER, 32'h0000_8000);
        write_register(REG_LOWER, 32'h0000_7fff);
        write_register(REG_MARGIN, 32'h0000_8000);
        push_sample(16'sh8000);
        push_sample(16'sd0);
        push_sample(16'sh7fff);
        push_sample(-16'sd1);

        // Random phases, each under fresh register settings
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                window_val = 0;
            end
            else if (roll == 1)
            begin
                window_val = 255;
            end
            else
            begin
                window_val = $urandom_range(1, 32);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                upper_val = $urandom_range(0, 65535);
                lower_val = $urandom_range(0, 65535);
            end
            else
            begin
                upper_val = $urandom_range(200, 6000);
                lower_val = int'($urandom_range(0, 5000)) - 1000;
            end
            roll = $urandom_range(0, 5);
            if (roll == 0)
            begin
                margin_val = 32768;
            end
            else if (roll == 1)
            begin
                margin_val = 0;
            end
            else if (roll == 2)
            begin
                margin_val = $urandom_range(0, 32768);
            end
            else
            begin
                margin_val = $urandom_range(0, 400);
            end
            write_register(REG_WINDOW, PDATA_W'(window_val));
            write_register(REG_UPPER, PDATA_W'(upper_val[15:0]));
            write_register(REG_LOWER, PDATA_W'(lower_val[15:0]));
            write_register(REG_MARGIN, PDATA_W'(margin_val));
            amp = $urandom_range(20, 4000);

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Idling comes and goes; none at all in the closing phase
                if (i % 32 == 0)
                begin
                    idling_on <= (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    s = SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
                end
                else if (roll < 75)
                begin
                    s = SAMPLE_W'($urandom_range(1000, 32767));
                end
                else if (roll < 88)
                begin
                    s = SAMPLE_W'(-int'($urandom_range(0, 32768)));
                end
                else
                begin
                    s = SAMPLE_W'($urandom);
                end
                push_sample(s);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("adaptive_window_clap_detector_top verification clean");
        end
        else
        begin
            $display("adaptive_window_clap_detector_top verification failed");
        end
        $finish;
    end

endmodule
